// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, switched off while reset is low
`define AMB_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// concurrent check that also holds while reset is low
`define AMB_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

// ===== design/ambps_pkg.sv =====
package ambps_pkg;

  // default image limits
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  // field widths
  localparam int unsigned ALPHA_W    = 8;
  localparam int unsigned PT_W       = 10;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned OUT_DATA_W = 24;

  // output queue, power of two, at least four
  localparam int unsigned OQ_DEPTH = 4;

  // register reset values
  localparam logic [ALPHA_W-1:0] THR_RST    = 8'd20;
  localparam logic [CFG_W-1:0]   WIDTH_RST  = 11'd1024;
  localparam logic [CFG_W-1:0]   HEIGHT_RST = 11'd1024;
  localparam logic [CFG_W-1:0]   CSTEP_RST  = 11'd1;
  localparam logic [CFG_W-1:0]   RSTEP_RST  = 11'd1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_WIDTH     = 3'd1,
    REG_HEIGHT    = 3'd2,
    REG_COL_STEP  = 3'd3,
    REG_ROW_STEP  = 3'd4
  } reg_idx_e;

  // one boundary point
  typedef struct packed {
    logic            last;
    logic [PT_W-1:0] y;
    logic [PT_W-1:0] x;
  } point_t;

  // points caused by one pixel, packed from index 0
  typedef struct packed {
    logic [1:0]       cnt;
    point_t [2:0]     pts;
  } push_t;

endpackage

// ===== design/ambps_ram.sv =====
module ambps_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = ambps_pkg::DEF_MAX_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ambps_outq.sv =====
module ambps_outq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ambps_pkg::push_t                    push_i,
  output logic                                room_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ambps_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast
);

  localparam int unsigned DEPTH = ambps_pkg::OQ_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned NW    = $clog2(DEPTH + 1);
  localparam int unsigned PAD_W = ambps_pkg::OUT_DATA_W - 2 * ambps_pkg::PT_W;

  ambps_pkg::point_t mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]     count_q, count_d;
  logic              pop;
  ambps_pkg::point_t head;

  assign head  = mem_q[rd_ptr_q];
  assign pop   = m_axis_tvalid && m_axis_tready;

  // room for a full bundle of three points
  assign room_o = (count_q <= NW'(DEPTH - 3));

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + PW'(pop);
    count_d  = count_q + NW'(push_i.cnt) - NW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // store up to three points in one cycle
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_i.cnt) begin
        mem_q[PW'(wr_ptr_q + PW'(i))] <= push_i.pts[i];
      end
    end
  end

  // output side
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = {{PAD_W{1'b0}}, head.y, head.x};
  assign m_axis_tlast  = head.last;

endmodule

// ===== design/alpha_mask_boundary_point_sampler_top.sv =====
// channel      | dir | handshake              | payload
// pixel in     | in  | s_axis_tvalid/tready   | tdata[7:0] alpha
// point out    | out | m_axis_tvalid/tready   | tdata[9:0] x, [19:10] y; tlast last of pixel
// config write | in  | cfg_we_i               | cfg_idx_i register, cfg_wdata_i value
//
// One pixel per cycle while the queue has room; the line store is read two columns ahead
// and written in the same cycle, so a pixel never waits on the memory port.
// Points leave at one per cycle while the receiver is ready, through a four-word queue;
// a pixel is taken while the queue has room for three, so rows that make two points per
// pixel run at the point rate.
// After reset and after every config write the block reloads its column window from the
// line store in ST_FETCH_CUR and then ST_FETCH_RGT; no clearing pass is made.
module alpha_mask_boundary_point_sampler_top #(
  parameter int unsigned MAX_WIDTH  = ambps_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = ambps_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel words
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ambps_pkg::ALPHA_W-1:0]       s_axis_tdata,   // [7:0] alpha
  // point words
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ambps_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // [9:0] point_x, [19:10] point_y
  output logic                                m_axis_tlast,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [ambps_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ambps_pkg::CFG_W-1:0]         cfg_wdata_i
);

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned YW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WEW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HEW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PTW = ambps_pkg::PT_W;

  typedef enum logic [1:0] {
    ST_FETCH_CUR,
    ST_FETCH_RGT,
    ST_RUN
  } state_e;

  state_e state_q;

  // configuration registers
  logic [ambps_pkg::ALPHA_W-1:0] thr_q;
  logic [ambps_pkg::CFG_W-1:0]   width_q, height_q, cstep_q, rstep_q;

  // position and sampling state
  logic [XW-1:0] col_q, col_d, cph_q, cph_d;
  logic [YW-1:0] row_q, row_d, rph_q, rph_d;
  logic          row_samp_prev_q, row_samp_prev_d;
  logic          col_samp_prev_q, col_samp_prev_d;

  // column window around the current pixel
  logic [1:0] cur_q, cur_d;
  logic [1:0] hold_q, hold_d;
  logic       use_hold_q;
  logic [1:0] head0_q, head1_q;
  logic       prev_op_q, prev2_op_q, prev_up_q;

  // effective limits
  logic [WEW-1:0] w_eff, cs_eff;
  logic [HEW-1:0] h_eff, rs_eff;

  logic           in_acc;
  logic           op;
  logic           last_col, last_row;
  logic           col_samp, row_samp;
  logic           c_ge1, c_ge2, r_ge1, r_ge2;
  logic [1:0]     rgt;
  logic [1:0]     new_c;
  logic           hit_a, hit_b, hit_c;
  logic [1:0]     n_pts;
  ambps_pkg::push_t push;
  logic           room;

  // line store signals
  logic          ram_re;
  logic [XW-1:0] ram_raddr;
  logic [1:0]    ram_rdata;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_RUN) && room;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= ambps_pkg::THR_RST;
      width_q  <= ambps_pkg::WIDTH_RST;
      height_q <= ambps_pkg::HEIGHT_RST;
      cstep_q  <= ambps_pkg::CSTEP_RST;
      rstep_q  <= ambps_pkg::RSTEP_RST;
    end else if (cfg_we_i) begin
      case (ambps_pkg::reg_idx_e'(cfg_idx_i))
        ambps_pkg::REG_THRESHOLD: thr_q    <= cfg_wdata_i[ambps_pkg::ALPHA_W-1:0];
        ambps_pkg::REG_WIDTH:     width_q  <= cfg_wdata_i;
        ambps_pkg::REG_HEIGHT:    height_q <= cfg_wdata_i;
        ambps_pkg::REG_COL_STEP:  cstep_q  <= cfg_wdata_i;
        ambps_pkg::REG_ROW_STEP:  rstep_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamp registers to 1 .. max
  always_comb begin
    w_eff  = (width_q == '0) ? WEW'(1) :
             (32'(width_q) > MAX_WIDTH) ? WEW'(MAX_WIDTH) : WEW'(width_q);
    cs_eff = (cstep_q == '0) ? WEW'(1) :
             (32'(cstep_q) > MAX_WIDTH) ? WEW'(MAX_WIDTH) : WEW'(cstep_q);
    h_eff  = (height_q == '0) ? HEW'(1) :
             (32'(height_q) > MAX_HEIGHT) ? HEW'(MAX_HEIGHT) : HEW'(height_q);
    rs_eff = (rstep_q == '0) ? HEW'(1) :
             (32'(rstep_q) > MAX_HEIGHT) ? HEW'(MAX_HEIGHT) : HEW'(rstep_q);
  end

  // position flags of the current pixel
  always_comb begin
    op       = (s_axis_tdata > thr_q);
    last_col = ((WEW'(col_q) + WEW'(1)) >= w_eff);
    last_row = ((HEW'(row_q) + HEW'(1)) >= h_eff);
    col_samp = (cph_q == '0);
    row_samp = (rph_q == '0);
    c_ge1    = (col_q != '0);
    c_ge2    = (WEW'(col_q) > WEW'(1));
    r_ge1    = (row_q != '0);
    r_ge2    = (HEW'(row_q) > HEW'(1));
    rgt      = use_hold_q ? hold_q : ram_rdata;
    new_c    = {cur_q[0], op};
  end

  // boundary tests: pixel above, left neighbour in last row, last pixel
  always_comb begin
    hit_a = r_ge1 && col_samp && row_samp_prev_q && cur_q[0] &&
            (!(c_ge1 && prev_up_q) || !(!last_col && rgt[0])) &&
            (!(r_ge2 && cur_q[1]) || !op);
    hit_b = last_row && c_ge1 && col_samp_prev_q && row_samp && prev_op_q &&
            (!(c_ge2 && prev2_op_q) || !op);
    hit_c = last_row && last_col && col_samp && row_samp && op;
  end

  // pack points in order, mark the final one
  always_comb begin
    push  = '0;
    n_pts = '0;
    if (in_acc && hit_a) begin
      push.pts[n_pts].x = PTW'(col_q);
      push.pts[n_pts].y = PTW'(YW'(row_q - YW'(1)));
      n_pts             = n_pts + 2'd1;
    end
    if (in_acc && hit_b) begin
      push.pts[n_pts].x = PTW'(XW'(col_q - XW'(1)));
      push.pts[n_pts].y = PTW'(row_q);
      n_pts             = n_pts + 2'd1;
    end
    if (in_acc && hit_c) begin
      push.pts[n_pts].x = PTW'(col_q);
      push.pts[n_pts].y = PTW'(row_q);
      n_pts             = n_pts + 2'd1;
    end
    if (n_pts != '0) begin
      push.pts[n_pts - 2'd1].last = 1'b1;
    end
    push.cnt = n_pts;
  end

  // next position and phases
  always_comb begin
    col_d           = col_q;
    row_d           = row_q;
    cph_d           = cph_q;
    rph_d           = rph_q;
    col_samp_prev_d = col_samp;
    row_samp_prev_d = row_samp_prev_q;
    if (last_col) begin
      col_d           = '0;
      cph_d           = '0;
      row_samp_prev_d = row_samp;
      if (last_row) begin
        row_d = '0;
        rph_d = '0;
      end else begin
        row_d = row_q + YW'(1);
        rph_d = ((HEW'(rph_q) + HEW'(1)) >= rs_eff) ? '0 : rph_q + YW'(1);
      end
    end else begin
      col_d = col_q + XW'(1);
      cph_d = ((WEW'(cph_q) + WEW'(1)) >= cs_eff) ? '0 : cph_q + XW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q           <= '0;
      row_q           <= '0;
      cph_q           <= '0;
      rph_q           <= '0;
      col_samp_prev_q <= 1'b0;
      row_samp_prev_q <= 1'b0;
    end else if (in_acc) begin
      col_q           <= col_d;
      row_q           <= row_d;
      cph_q           <= cph_d;
      rph_q           <= rph_d;
      col_samp_prev_q <= col_samp_prev_d;
      row_samp_prev_q <= row_samp_prev_d;
    end
  end

  // window for the next pixel; row wrap takes columns 0 and 1 from the shadow
  always_comb begin
    if (last_col) begin
      cur_d  = c_ge1 ? head0_q : new_c;
      hold_d = (col_q == XW'(1)) ? new_c : head1_q;
    end else begin
      cur_d  = rgt;
      hold_d = hold_q;
    end
  end

  // line store access: reload after reset or config, else read two columns ahead
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = col_q;
    case (state_q)
      ST_FETCH_CUR: begin
        ram_re    = 1'b1;
        ram_raddr = col_q;
      end
      ST_FETCH_RGT: begin
        ram_re    = 1'b1;
        ram_raddr = col_q + XW'(1);
      end
      ST_RUN: begin
        ram_re    = in_acc && !last_col;
        ram_raddr = XW'(WEW'(col_q) + WEW'(2));
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // sequencer and window select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FETCH_CUR;
      use_hold_q <= 1'b0;
    end else if (cfg_we_i) begin
      state_q    <= ST_FETCH_CUR;
    end else begin
      case (state_q)
        ST_FETCH_CUR: begin
          state_q <= ST_FETCH_RGT;
        end
        ST_FETCH_RGT: begin
          state_q    <= ST_RUN;
          use_hold_q <= 1'b0;
        end
        ST_RUN: begin
          if (in_acc) begin
            use_hold_q <= last_col;
          end
        end
        default: begin
          state_q <= ST_FETCH_CUR;
        end
      endcase
    end
  end

  // window payload
  always_ff @(posedge clk_i) begin
    if (!cfg_we_i && state_q == ST_FETCH_RGT) begin
      cur_q <= ram_rdata;
    end else if (in_acc) begin
      cur_q <= cur_d;
    end
    if (in_acc) begin
      hold_q     <= hold_d;
      prev_op_q  <= op;
      prev2_op_q <= prev_op_q;
      prev_up_q  <= cur_q[0];
      if (col_q == '0) begin
        head0_q <= new_c;
      end
      if (col_q == XW'(1)) begin
        head1_q <= new_c;
      end
    end
  end

  ambps_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (col_q),
    .wdata_i (new_c),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ambps_outq u_outq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .room_o        (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== design/ambps_checker.sv =====
`include "assert_macros.svh"

module ambps_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [ambps_pkg::ALPHA_W-1:0]    s_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [ambps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast,
  input logic                             cfg_we_i,
  input logic [ambps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [ambps_pkg::CFG_W-1:0]      cfg_wdata_i
);

  // a stalled point word holds
  `AMB_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // points of one pixel come out without gaps
  `AMB_ASSERT(a_run_gapless, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)

  // a config write holds off pixels while the window reloads in both fetch states
  `AMB_ASSERT(a_cfg_reload, clk_i, rst_ni, cfg_we_i |=> !s_axis_tready ##1 !s_axis_tready)

  // nothing moves while reset is held
  `AMB_ASSERT_NR(a_reset_quiet, clk_i, !rst_ni |-> !m_axis_tvalid && !s_axis_tready)

endmodule

bind alpha_mask_boundary_point_sampler_top ambps_checker u_ambps_checker (.*);
